[hw/rtl/ddo_pkg.sv]
// Shared types, constants and CORDIC arctangent table for the odometry block.
package ddo_pkg;

    localparam int unsigned TabLen   = 24;
    localparam int unsigned CordW    = 34;   // Q.30 datapath with headroom
    localparam int unsigned ZW       = 32;
    localparam logic [33:0] GainQ30  = 34'd652032874;
    localparam logic [35:0] TwoPiQ16 = 36'd411775;

    localparam logic [1:0] RegRadius = 2'd0;
    localparam logic [1:0] RegTrack  = 2'd1;
    localparam logic [1:0] RegPeriod = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_CORD,
        S_POS,
        S_POS2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [CordW-1:0] x;
        logic signed [CordW-1:0] y;
        logic signed [ZW-1:0]    z;
    } t_cord;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/ddo_cordic_cell.sv]
// One registered CORDIC rotation cell with a fixed shift.
module ddo_cordic_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  ddo_pkg::t_cord i_cord,
    output ddo_pkg::t_cord o_cord
);

    ddo_pkg::t_cord r_cord;
    ddo_pkg::t_cord n_cord;

    always_comb begin
        n_cord = i_cord;
        if (!i_cord.z[ddo_pkg::ZW-1]) begin
            n_cord.x = i_cord.x - (i_cord.y >>> STAGE);
            n_cord.y = i_cord.y + (i_cord.x >>> STAGE);
            n_cord.z = i_cord.z - ddo_pkg::atan_q30(5'(STAGE));
        end else begin
            n_cord.x = i_cord.x + (i_cord.y >>> STAGE);
            n_cord.y = i_cord.y - (i_cord.x >>> STAGE);
            n_cord.z = i_cord.z + ddo_pkg::atan_q30(5'(STAGE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cord <= n_cord;
        end
    end

    assign o_cord = r_cord;

endmodule

[hw/rtl/ddo_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module ddo_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [51:0] i_num,
    input  logic [35:0] i_den,
    output logic        o_done,
    output logic [51:0] o_quo
);

    logic [51:0] r_quo;
    logic [36:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [36:0] n_try;

    assign n_try = {r_rem[35:0], r_quo[51]} - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // raised once the last quotient bit has landed in r_quo
            r_done <= r_busy && (r_cnt == 6'd0) && !i_start;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd51;
            end else if (r_busy) begin
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!n_try[36]) begin
                r_rem <= n_try;
                r_quo <= {r_quo[50:0], 1'b1};
            end else begin
                r_rem <= {r_rem[35:0], r_quo[51]};
                r_quo <= {r_quo[50:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[hw/rtl/diff_drive_odometry.sv]
// Top level: differential-drive odometry with divider and CORDIC cell chain.
// One word at a time: after a word is accepted it passes through a multiply,
// the 52-bit restoring divider for the heading step, the chain of registered
// rotation cells, and a multiply and accumulate. o_ready is low while a word
// is processed and the result sits in an output register until taken; the
// next word can be accepted only after that.
module diff_drive_odometry #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_left_speed,
    input  logic signed [15:0] i_right_speed,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [15:0]        o_heading_out
);

    logic [15:0] r_radius, r_track, r_period;
    logic signed [31:0] r_px, r_py;
    logic [15:0] r_head;
    ddo_pkg::t_state r_st, n_st;
    logic [5:0] r_cnt;
    logic signed [16:0] r_sum, r_dif;
    logic [31:0] r_rt;
    logic signed [51:0] r_num;     // D*rt*8
    logic signed [48:0] r_dist_full;
    logic signed [31:0] r_dist;
    logic r_flip;
    logic signed [47:0] r_mx, r_my;
    logic r_oval;
    logic signed [48:0] w_dprod, w_sprod;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd6554;
            r_track  <= 16'd2048;
            r_period <= 16'd6554;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ddo_pkg::RegRadius: r_radius <= i_cfg_data;
                ddo_pkg::RegTrack:  r_track  <= i_cfg_data;
                ddo_pkg::RegPeriod: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divider
    logic [35:0] w_den;
    logic [51:0] w_mag, w_quo;
    logic w_div_start, w_div_done;
    assign w_den = (r_track == 16'd0 ? 36'd1 : {20'd0, r_track}) * ddo_pkg::TwoPiQ16;
    assign w_mag = r_num[51] ? 52'(-r_num) : 52'(r_num);
    assign w_div_start = (r_st == ddo_pkg::S_MUL) && (r_cnt == 6'd1);

    ddo_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_mag + 52'(w_den >> 1)),
        .i_den  (w_den),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    logic [15:0] w_step, w_new_head;
    assign w_step     = r_num[51] ? 16'(-w_quo[15:0]) : w_quo[15:0];
    assign w_new_head = r_head + w_step;

    // CORDIC chain
    ddo_pkg::t_cord w_chain [CORDIC_STEPS+1];
    logic signed [15:0] w_ang;
    logic signed [16:0] w_fold;
    logic w_flip;

    always_comb begin
        w_ang  = signed'(r_head);
        w_flip = 1'b0;
        w_fold = 17'(w_ang);
        if (w_ang > 16'sd16384) begin
            w_fold = 17'(w_ang) - 17'sd32768;
            w_flip = 1'b1;
        end else if (w_ang < -16'sd16384) begin
            w_fold = 17'(w_ang) + 17'sd32768;
            w_flip = 1'b1;
        end
        w_chain[0].x = signed'(ddo_pkg::GainQ30);
        w_chain[0].y = '0;
        w_chain[0].z = {w_fold[15:0], 16'd0};
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ddo_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_cord(w_chain[g]),
            .o_cord(w_chain[g+1])
        );
    end

    logic signed [19:0] w_c16, w_s16;
    assign w_c16 = 20'((w_chain[CORDIC_STEPS].x + 34'sd8192) >>> 14);
    assign w_s16 = 20'((w_chain[CORDIC_STEPS].y + 34'sd8192) >>> 14);

    function automatic logic signed [31:0] sat(input logic signed [32:0] v);
        if (v > 33'sd2147483647) return 32'h7fffffff;
        if (v < -33'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    always_comb begin
        n_st = r_st;
        case (r_st)
            ddo_pkg::S_IDLE: if (i_valid) n_st = ddo_pkg::S_MUL;
            ddo_pkg::S_MUL:  if (r_cnt == 6'd1) n_st = ddo_pkg::S_DIV;
            ddo_pkg::S_DIV:  if (w_div_done) n_st = ddo_pkg::S_CORD;
            ddo_pkg::S_CORD: if (r_cnt == 6'(CORDIC_STEPS)) n_st = ddo_pkg::S_POS;
            ddo_pkg::S_POS:  n_st = ddo_pkg::S_POS2;
            ddo_pkg::S_POS2: n_st = ddo_pkg::S_OUT;
            ddo_pkg::S_OUT:  if (!r_oval) n_st = ddo_pkg::S_IDLE;
            default:         n_st = ddo_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ddo_pkg::S_IDLE;
            r_cnt  <= '0;
            r_px   <= '0;
            r_py   <= '0;
            r_head <= '0;
            r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_oval && i_ready) r_oval <= 1'b0;
            case (r_st)
                ddo_pkg::S_IDLE: r_cnt <= '0;
                ddo_pkg::S_MUL:  r_cnt <= r_cnt + 6'd1;
                ddo_pkg::S_DIV:  if (w_div_done) begin
                    r_head <= 16'(w_new_head);
                    r_cnt  <= '0;
                end
                ddo_pkg::S_CORD: r_cnt <= r_cnt + 6'd1;
                ddo_pkg::S_POS2: begin
                    r_px   <= sat(33'(r_px) + 33'(r_mx >>> 24));
                    r_py   <= sat(33'(r_py) + 33'(r_my >>> 24));
                end
                ddo_pkg::S_OUT: if (!r_oval && n_st == ddo_pkg::S_IDLE && r_cnt == 6'd0) begin
                    r_cnt <= '0;
                end
                default: ;
            endcase
            if (r_st == ddo_pkg::S_POS2) r_oval <= 1'b1;
        end
    end

    // full-width signed products of the wheel terms with radius*period
    assign w_dprod = r_dif * signed'({1'b0, r_rt});
    assign w_sprod = r_sum * signed'({1'b0, r_rt});

    // payload datapath
    always_ff @(posedge i_clk) begin
        if (r_st == ddo_pkg::S_IDLE && i_valid) begin
            r_sum <= 17'(i_right_speed) + 17'(i_left_speed);
            r_dif <= 17'(i_left_speed) - 17'(i_right_speed);
            r_rt  <= r_radius * r_period;
        end
        if (r_st == ddo_pkg::S_MUL && r_cnt == 6'd0) begin
            r_num       <= {w_dprod, 3'b000};
            r_dist_full <= w_sprod;
        end
        if (r_st == ddo_pkg::S_CORD && r_cnt == 6'd0) begin
            r_dist <= 32'(r_dist_full >>> 17);
            r_flip <= w_flip;
        end
        if (r_st == ddo_pkg::S_POS) begin
            r_mx <= r_dist * (r_flip ? -w_c16 : w_c16);
            r_my <= r_dist * (r_flip ? -w_s16 : w_s16);
        end
    end

    assign o_ready       = (r_st == ddo_pkg::S_IDLE);
    assign o_valid       = r_oval;
    assign o_pos_x       = r_px;
    assign o_pos_y       = r_py;
    assign o_heading_out = r_head;

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("accepting while result pending");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_st == ddo_pkg::S_DIV) else $error("stray divider done");
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> r_st == ddo_pkg::S_OUT) else $error("result outside output state");

endmodule
